// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Synthesis builds define SYNTH so that
// every use expands to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/qbez_pkg.sv -----
// ----------------------------------------------------------------------------
// Quartic Bezier evaluator package
// Widths, register codes, shared types and the coefficient scaling function.
// ----------------------------------------------------------------------------
`default_nettype none

package qbez_pkg;

    localparam int COORD_W    = 16;
    localparam int FRAC_W     = 12;
    localparam int POS_W      = FRAC_W + 1;
    localparam int NUM_PTS    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2 * COORD_W;

    // Binomial factors 4 and 6 are folded into the stored coefficients.
    localparam int COEF_W     = COORD_W + 3;
    localparam int SQ_W       = 2 * FRAC_W + 1;
    localparam int MONO_W     = 4 * FRAC_W + 1;
    localparam int PART_LO_W  = MONO_W / 2;
    localparam int PART_HI_W  = MONO_W - PART_LO_W;
    localparam int PLO_W      = COEF_W + PART_LO_W + 1;
    localparam int PHI_W      = COEF_W + PART_HI_W + 1;
    localparam int LSUM_W     = PLO_W + 3;
    localparam int ACC_W      = 4 * FRAC_W + COORD_W;
    localparam int HSUM_W     = ACC_W - PART_LO_W;

    localparam logic [POS_W-1:0] ONE        = POS_W'(1) << FRAC_W;
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (4 * FRAC_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START,
        REG_GUIDE1,
        REG_GUIDE2,
        REG_GUIDE3,
        REG_END
    } t_reg_idx;

    typedef logic signed [COORD_W-1:0]       t_coord;
    typedef logic signed [COEF_W-1:0]        t_coef;
    typedef logic [NUM_PTS-1:0][COEF_W-1:0]  t_coef_vec;
    typedef logic [NUM_PTS-1:0][MONO_W-1:0]  t_mono_vec;
    typedef logic signed [PLO_W-1:0]         t_plo;
    typedef logic signed [PHI_W-1:0]         t_phi;
    typedef logic signed [LSUM_W-1:0]        t_lsum;
    typedef logic signed [HSUM_W-1:0]        t_hsum;
    typedef logic signed [ACC_W-1:0]         t_acc;

    // Stage advance enables for one coordinate datapath.
    typedef struct packed {
        logic prod;
        logic psum;
        logic sum;
        logic fin;
    } t_dp_en;

    // Scales a control coordinate by its binomial factor.
    function automatic t_coef coef_scale(t_coord c, t_reg_idx idx);
        t_coef c_ext;
        t_coef res;
        c_ext = t_coef'(c);
        case (idx) inside
            REG_GUIDE1, REG_GUIDE3: res = c_ext <<< 2;
            REG_GUIDE2:             res = (c_ext <<< 2) + (c_ext <<< 1);
            default:                res = c_ext;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/qbez_pos_if.sv -----
// ----------------------------------------------------------------------------
// Curve position channel
// Valid/ready channel carrying one curve position per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qbez_pos_if;
    logic                         valid;
    logic                         ready;
    logic [qbez_pkg::POS_W-1:0]   curve_position;

    modport source(output valid, output curve_position, input ready);
    modport sink(input valid, input curve_position, output ready);
endinterface

`default_nettype wire

// ----- hdl/qbez_point_if.sv -----
// ----------------------------------------------------------------------------
// Curve point channel
// Valid/ready channel carrying one rounded curve point per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qbez_point_if;
    logic                               valid;
    logic                               ready;
    logic signed [qbez_pkg::COORD_W-1:0] point_x;
    logic signed [qbez_pkg::COORD_W-1:0] point_y;

    modport source(output valid, output point_x, output point_y, input ready);
    modport sink(input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

// ----- hdl/qbez_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface qbez_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [qbez_pkg::CFG_IDX_W-1:0]    index;
    logic [qbez_pkg::CFG_DATA_W-1:0]   data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/qbez_coord_path.sv -----
// ----------------------------------------------------------------------------
// Quartic Bezier coordinate datapath
// Weighted sum of five scaled coefficients over four pipeline stages:
// split partial products, partial sums, sums, and rounding with output.
// ----------------------------------------------------------------------------
`default_nettype none

module qbez_coord_path (
    input  logic                  i_clk,
    input  qbez_pkg::t_dp_en      i_en,
    input  qbez_pkg::t_coef_vec   i_coef,
    input  qbez_pkg::t_mono_vec   i_mono,
    output qbez_pkg::t_coord      o_coord
);

    qbez_pkg::t_plo   r_plo [qbez_pkg::NUM_PTS];
    qbez_pkg::t_phi   r_phi [qbez_pkg::NUM_PTS];
    qbez_pkg::t_lsum  r_alo;
    qbez_pkg::t_lsum  r_blo;
    qbez_pkg::t_hsum  r_ahi;
    qbez_pkg::t_hsum  r_bhi;
    qbez_pkg::t_lsum  r_lo;
    qbez_pkg::t_hsum  r_hi;
    qbez_pkg::t_coord r_coord;

    logic [qbez_pkg::ACC_W-1:0] total;

    // Each monomial is split into a low and a high half so that every
    // multiplier stays narrow; the high halves are weighted by 2^PART_LO_W.
    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            for (int k = 0; k < qbez_pkg::NUM_PTS; k++) begin
                r_plo[k] <= $signed(i_coef[k])
                          * $signed({1'b0, i_mono[k][qbez_pkg::PART_LO_W-1:0]});
                r_phi[k] <= $signed(i_coef[k])
                          * $signed({1'b0, i_mono[k][qbez_pkg::MONO_W-1:qbez_pkg::PART_LO_W]});
            end
        end
    end

    // High sums only feed bits at and above PART_LO_W, so they wrap safely.
    always_ff @(posedge i_clk) begin
        if (i_en.psum) begin
            r_alo <= qbez_pkg::t_lsum'(r_plo[0]) + qbez_pkg::t_lsum'(r_plo[1])
                   + qbez_pkg::t_lsum'(r_plo[2]);
            r_blo <= qbez_pkg::t_lsum'(r_plo[3]) + qbez_pkg::t_lsum'(r_plo[4]);
            r_ahi <= qbez_pkg::t_hsum'(r_phi[0]) + qbez_pkg::t_hsum'(r_phi[1])
                   + qbez_pkg::t_hsum'(r_phi[2]);
            r_bhi <= qbez_pkg::t_hsum'(r_phi[3]) + qbez_pkg::t_hsum'(r_phi[4]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_lo <= r_alo + r_blo;
            r_hi <= r_ahi + r_bhi;
        end
    end

    always_comb begin
        total = qbez_pkg::t_acc'({r_hi, {qbez_pkg::PART_LO_W{1'b0}}})
              + qbez_pkg::t_acc'(r_lo) + qbez_pkg::ROUND_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.fin) begin
            r_coord <= total[qbez_pkg::ACC_W-1 -: qbez_pkg::COORD_W];
        end
    end

    assign o_coord = r_coord;

endmodule

`default_nettype wire

// ----- hdl/quartic_bezier_point_evaluator_unit.sv -----
// ----------------------------------------------------------------------------
// Quartic Bezier point evaluator
// Pipeline: seven register stages; a point becomes valid at the output once
// its position has been accepted and has moved through all of them.
// Throughput: one point per cycle; an occupied stage holds while every stage
// after it is full and the output is stalled, and empty stages keep filling.
// Reset: synchronous, active low; clears all stage valid bits and sets all
// five control points to zero. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module quartic_bezier_point_evaluator_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qbez_pos_if.sink         i_pos,
    qbez_cfg_if.sink         i_cfg,
    qbez_point_if.source     o_point
);

    localparam int N_STG = 7;

    logic [N_STG-1:0] r_v;
    logic [N_STG-1:0] n_v;
    logic [N_STG-1:0] stage_en;

    qbez_pkg::t_coef_vec r_cx;
    qbez_pkg::t_coef_vec r_cy;

    logic [qbez_pkg::POS_W-1:0] r_t;
    logic [qbez_pkg::POS_W-1:0] r_s;
    logic [qbez_pkg::POS_W-1:0] pos_sat;
    logic [qbez_pkg::SQ_W-1:0]  r_tt;
    logic [qbez_pkg::SQ_W-1:0]  r_ss;
    logic [qbez_pkg::SQ_W-1:0]  r_ts;
    qbez_pkg::t_mono_vec        r_mono;

    qbez_pkg::t_dp_en dp_en;
    qbez_pkg::t_coord coord_x;
    qbez_pkg::t_coord coord_y;

    qbez_pkg::t_reg_idx cfg_idx;
    qbez_pkg::t_coord   cfg_x;
    qbez_pkg::t_coord   cfg_y;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        stage_en[N_STG-1] = !r_v[N_STG-1] || o_point.ready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
        n_v[0] = i_pos.valid;
        for (int k = 1; k < N_STG; k++) begin
            n_v[k] = r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < N_STG; k++) begin
                if (stage_en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    assign i_pos.ready = stage_en[0];

    // Configuration registers hold coefficients already scaled by 1, 4 or 6.
    assign i_cfg.ready = 1'b1;
    assign cfg_idx     = qbez_pkg::t_reg_idx'(i_cfg.index);
    assign cfg_x       = i_cfg.data[qbez_pkg::COORD_W-1:0];
    assign cfg_y       = i_cfg.data[2*qbez_pkg::COORD_W-1:qbez_pkg::COORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (cfg_idx)
                qbez_pkg::REG_START: begin
                    r_cx[0] <= qbez_pkg::coef_scale(cfg_x, cfg_idx);
                    r_cy[0] <= qbez_pkg::coef_scale(cfg_y, cfg_idx);
                end
                qbez_pkg::REG_GUIDE1: begin
                    r_cx[1] <= qbez_pkg::coef_scale(cfg_x, cfg_idx);
                    r_cy[1] <= qbez_pkg::coef_scale(cfg_y, cfg_idx);
                end
                qbez_pkg::REG_GUIDE2: begin
                    r_cx[2] <= qbez_pkg::coef_scale(cfg_x, cfg_idx);
                    r_cy[2] <= qbez_pkg::coef_scale(cfg_y, cfg_idx);
                end
                qbez_pkg::REG_GUIDE3: begin
                    r_cx[3] <= qbez_pkg::coef_scale(cfg_x, cfg_idx);
                    r_cy[3] <= qbez_pkg::coef_scale(cfg_y, cfg_idx);
                end
                qbez_pkg::REG_END: begin
                    r_cx[4] <= qbez_pkg::coef_scale(cfg_x, cfg_idx);
                    r_cy[4] <= qbez_pkg::coef_scale(cfg_y, cfg_idx);
                end
                default: begin
                end
            endcase
        end
    end

    // Positions beyond one are clamped to one, which yields the end point.
    assign pos_sat = (i_pos.curve_position > qbez_pkg::ONE) ? qbez_pkg::ONE
                                                            : i_pos.curve_position;

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_t <= pos_sat;
            r_s <= qbez_pkg::ONE - pos_sat;
        end
        if (stage_en[1]) begin
            r_tt <= r_t * r_t;
            r_ss <= r_s * r_s;
            r_ts <= r_t * r_s;
        end
        if (stage_en[2]) begin
            r_mono[0] <= r_ss * r_ss;
            r_mono[1] <= r_ts * r_ss;
            r_mono[2] <= r_tt * r_ss;
            r_mono[3] <= r_ts * r_tt;
            r_mono[4] <= r_tt * r_tt;
        end
    end

    assign dp_en.prod = stage_en[3];
    assign dp_en.psum = stage_en[4];
    assign dp_en.sum  = stage_en[5];
    assign dp_en.fin  = stage_en[6];

    qbez_coord_path u_path_x (
        .i_clk   (i_clk),
        .i_en    (dp_en),
        .i_coef  (r_cx),
        .i_mono  (r_mono),
        .o_coord (coord_x)
    );

    qbez_coord_path u_path_y (
        .i_clk   (i_clk),
        .i_en    (dp_en),
        .i_coef  (r_cy),
        .i_mono  (r_mono),
        .o_coord (coord_y)
    );

    assign o_point.valid   = r_v[N_STG-1];
    assign o_point.point_x = coord_x;
    assign o_point.point_y = coord_y;

    `ASSERT_NXT(a_accept_fills, i_clk, i_rst_n, i_pos.valid && i_pos.ready, r_v[0])
    `ASSERT_IMP(a_pos_pair, i_clk, i_rst_n, r_v[0], (r_t + r_s) == qbez_pkg::ONE)
    `ASSERT_IMP(a_full_stall, i_clk, i_rst_n, !i_pos.ready, (&r_v) && !o_point.ready)
    `ASSERT_NXT(a_mid_hold, i_clk, i_rst_n, r_v[3] && !stage_en[3], r_v[3])

endmodule

`default_nettype wire
